// ----- src/dvf_pkg.sv -----
// Shared types, constants and tables for the drum voice finish stage.
package dvf_pkg;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_TRIGGER = 2'd1,
		OP_GATE    = 2'd2,
		OP_PANIC   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] dry_sample;
		logic signed [15:0] wet_sample;
		logic [6:0]         velocity;
		logic               gate_level;
	} cmd_t;

	// configuration register indexes
	localparam logic [2:0] CFG_MIX_AMOUNT      = 3'd0;
	localparam logic [2:0] CFG_OUTPUT_LEVEL    = 3'd1;
	localparam logic [2:0] CFG_DECAY_FACTOR    = 3'd2;
	localparam logic [2:0] CFG_RESOLUTION_BITS = 3'd3;
	localparam logic [2:0] CFG_HOLD_COUNT      = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [15:0] MIX_RESET        = 16'd0;
	localparam logic [15:0] LEVEL_RESET      = 16'd55706;
	localparam logic [23:0] DECAY_RESET      = 24'd16769666;
	localparam logic [4:0]  BITS_RESET       = 5'd16;
	localparam logic [4:0]  HOLD_RESET       = 5'd1;
	localparam logic [6:0]  VELOCITY_RESET   = 7'd100;

	// envelope of 0.00001 in Q0.24
	localparam logic [23:0] ENV_THRESHOLD = 24'd167;

	localparam int QUEUE_DEPTH = 2;

	// quotient bits of the level reconstruction divide
	localparam int DIV_STEPS = 17;

	localparam longint ACCENT_DIV = 635;

	// accent = round((127 + 4*v) * 2^24 / 635), saturated to 24 bits
	function automatic logic [127:0][23:0] build_accent();
		logic [127:0][23:0] tbl;
		longint num;
		for (int v = 0; v < 128; v++) begin
			num = (longint'(127 + 4 * v) <<< 24) + 64'sd317;
			num = num / ACCENT_DIV;
			if (num > 64'sd16777215) num = 64'sd16777215;
			tbl[v] = 24'(num);
		end
		return tbl;
	endfunction

	localparam logic [127:0][23:0] ACCENT_TABLE = build_accent();

endpackage

// ----- src/dvf_front.sv -----
// Front end: accepts input transfers, decodes them into commands, short queue.
module dvf_front
	import dvf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	output logic        q_valid,
	output cmd_t        q_cmd,
	input  logic        q_pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	cmd_t              cmd_in;
	logic              push;
	logic              pop;

	always_comb begin
		cmd_in.op         = op_t'(s_axis_tuser);
		cmd_in.dry_sample = s_axis_tdata[15:0];
		cmd_in.wet_sample = s_axis_tdata[31:16];
		cmd_in.velocity   = s_axis_tdata[38:32];
		cmd_in.gate_level = s_axis_tdata[39];
	end

	assign s_axis_tready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign q_valid       = (count_q != '0);
	assign q_cmd         = mem_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != '0)
		else $error("pop from empty queue");
`endif

endmodule

// ----- src/dvf_back.sv -----
// Back end: envelope, blend, gain, sample-and-hold and bit crushing sequencer.
module dvf_back
	import dvf_pkg::*;
#(
	parameter int CHUNK_LENGTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   q_valid,
	input  cmd_t                   q_cmd,
	output logic                   q_pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata
);

	localparam int POS_W = $clog2(CHUNK_LENGTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BLEND,
		S_ENV_HI,
		S_ENV_LO,
		S_TRIM,
		S_LEVEL,
		S_SHAPE,
		S_QUANT,
		S_QROUND,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] mix_q;
	logic [15:0] level_q;
	logic [23:0] decay_q;
	logic [4:0]  bits_q;
	logic [4:0]  hold_q;

	// voice state
	logic [23:0]      env_q;
	logic [15:0]      held_q;
	logic [4:0]       hold_rem_q;
	logic             trig_pend_q;
	logic             gate_was_q;
	logic [6:0]       last_vel_q;
	logic [POS_W-1:0] chunk_pos_q;
	logic             rendering_q;

	// datapath registers
	cmd_t               cmd_q;
	logic signed [33:0] blend_q;
	logic [47:0]        dec_q;
	logic signed [46:0] phi_q;
	logic signed [46:0] plo_q;
	logic signed [32:0] t_q;
	logic signed [49:0] lvl_q;
	logic [31:0]        u_q;
	logic [46:0]        qprod_q;
	logic [15:0]        rem_q;
	logic [16:0]        dvd_q;
	logic [16:0]        quot_q;
	logic [4:0]         div_cnt_q;
	logic [15:0]        res_q;
	logic               out_valid_q;
	logic [15:0]        out_data_q;

	logic               out_free;
	logic               cfg_we;
	logic signed [16:0] diff_c;
	logic signed [33:0] mixprod_c;
	logic signed [33:0] blend_c;
	logic [12:0]        env_part_c;
	logic signed [46:0] env_mul_c;
	logic [58:0]        tsum_c;
	logic signed [49:0] lvl_c;
	logic signed [49:0] e31sum_c;
	logic signed [33:0] e31_c;
	logic signed [33:0] psum_c;
	logic signed [17:0] pr_c;
	logic [15:0]        pass_c;
	logic signed [34:0] s_c;
	logic [31:0]        u_c;
	logic [3:0]         bits_eff_c;
	logic [14:0]        lmax_c;
	logic [47:0]        qsum_c;
	logic [16:0]        trial_c;
	logic               ge_c;
	logic [15:0]        rem_next_c;
	logic [16:0]        quot_next_c;
	logic [15:0]        crushed_c;
	logic [47:0]        nesum_c;
	logic [23:0]        ne_c;
	logic [6:0]         trig_vel_c;
	logic [23:0]        accent_c;
	logic               rend_now_c;
	logic [4:0]         hc_c;

	assign cfg_ready     = 1'b1;
	assign cfg_we        = cfg_valid && cfg_ready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign q_pop         = (state_q == S_IDLE) && q_valid;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// blend: dry * 2^16 + (wet - dry) * mix
	assign diff_c    = {cmd_q.wet_sample[15], cmd_q.wet_sample}
		- {cmd_q.dry_sample[15], cmd_q.dry_sample};
	assign mixprod_c = diff_c * $signed({1'b0, mix_q});
	assign blend_c   = $signed({{2{cmd_q.dry_sample[15]}}, cmd_q.dry_sample, 16'b0}) + mixprod_c;

	// envelope product split into two 12-bit halves on one multiplier
	assign env_part_c = (state_q == S_ENV_HI) ? {1'b0, env_q[23:12]} : {1'b0, env_q[11:0]};
	assign env_mul_c  = blend_q * $signed(env_part_c);
	assign tsum_c     = {phi_q, 12'b0} + {{12{plo_q[46]}}, plo_q} + 59'd8388608;

	assign lvl_c    = t_q * $signed({1'b0, level_q});
	assign e31sum_c = lvl_q + 50'sd32768;
	assign e31_c    = e31sum_c[49:16];

	// pass-through rounding and saturation
	assign psum_c = e31_c + 34'sd32768;
	assign pr_c   = psum_c[33:16];
	always_comb begin
		if (pr_c > 18'sd32767)       pass_c = 16'h7FFF;
		else if (pr_c < -18'sd32768) pass_c = 16'h8000;
		else                         pass_c = pr_c[15:0];
	end

	// unipolar value for crushing, clamped to [0, 2^32)
	assign s_c = {e31_c[33], e31_c} + 35'sd2147483648;
	always_comb begin
		if (s_c[34])                    u_c = '0;
		else if (s_c[33:32] != 2'b00)   u_c = 32'hFFFF_FFFF;
		else                            u_c = s_c[31:0];
	end

	assign bits_eff_c = (bits_q < 5'd2) ? 4'd2 : bits_q[3:0];
	assign lmax_c     = 15'((16'd1 << bits_eff_c) - 16'd1);
	assign qsum_c     = {1'b0, qprod_q} + 48'd2147483648;

	// restoring divide of (2^17*q + L) by 2L
	assign trial_c     = {rem_q, dvd_q[16]};
	assign ge_c        = trial_c >= {1'b0, lmax_c, 1'b0};
	assign rem_next_c  = ge_c ? 16'(trial_c - {1'b0, lmax_c, 1'b0}) : trial_c[15:0];
	assign quot_next_c = {quot_q[15:0], ge_c};
	assign crushed_c   = quot_next_c[16] ? 16'h7FFF : {~quot_next_c[15], quot_next_c[14:0]};

	assign nesum_c = dec_q + 48'd8388608;
	assign ne_c    = nesum_c[47:24];

	assign trig_vel_c = (q_cmd.op == OP_TRIGGER) ? q_cmd.velocity : last_vel_q;
	assign accent_c   = ACCENT_TABLE[trig_vel_c];
	assign rend_now_c = (chunk_pos_q == '0) ? (trig_pend_q || (env_q > ENV_THRESHOLD))
		: rendering_q;
	assign hc_c       = (hold_q == '0) ? 5'd1 : hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mix_q       <= MIX_RESET;
			level_q     <= LEVEL_RESET;
			decay_q     <= DECAY_RESET;
			bits_q      <= BITS_RESET;
			hold_q      <= HOLD_RESET;
			env_q       <= '0;
			held_q      <= '0;
			hold_rem_q  <= '0;
			trig_pend_q <= 1'b0;
			gate_was_q  <= 1'b0;
			last_vel_q  <= VELOCITY_RESET;
			chunk_pos_q <= '0;
			rendering_q <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIX_AMOUNT:      mix_q   <= cfg_data[15:0];
					CFG_OUTPUT_LEVEL:    level_q <= cfg_data[15:0];
					CFG_DECAY_FACTOR:    decay_q <= cfg_data[23:0];
					CFG_RESOLUTION_BITS: bits_q  <= cfg_data[4:0];
					CFG_HOLD_COUNT:      hold_q  <= cfg_data[4:0];
					default: ;
				endcase
			end

			// the emit step reloads the result register itself
			if (out_valid_q && m_axis_tready && state_q != S_EMIT) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_cmd;
						case (q_cmd.op)
							OP_TRIGGER: begin
								last_vel_q  <= trig_vel_c;
								trig_pend_q <= 1'b1;
								hold_rem_q  <= '0;
								if (accent_c > env_q) env_q <= accent_c;
							end
							OP_GATE: begin
								gate_was_q <= q_cmd.gate_level;
								if (q_cmd.gate_level && !gate_was_q) begin
									trig_pend_q <= 1'b1;
									hold_rem_q  <= '0;
									if (accent_c > env_q) env_q <= accent_c;
								end
							end
							OP_PANIC: begin
								trig_pend_q <= 1'b0;
								gate_was_q  <= 1'b0;
								env_q       <= '0;
								held_q      <= '0;
								hold_rem_q  <= '0;
							end
							default: begin
								rendering_q <= rend_now_c;
								if (chunk_pos_q == '0) trig_pend_q <= 1'b0;
								chunk_pos_q <= (chunk_pos_q == POS_W'(CHUNK_LENGTH - 1))
									? '0 : chunk_pos_q + 1'b1;
								if (rend_now_c) begin
									state_q <= S_BLEND;
								end else begin
									res_q   <= '0;
									state_q <= S_EMIT;
								end
							end
						endcase
					end
				end
				S_BLEND: begin
					blend_q <= blend_c;
					dec_q   <= env_q * decay_q;
					state_q <= S_ENV_HI;
				end
				S_ENV_HI: begin
					phi_q   <= env_mul_c;
					state_q <= S_ENV_LO;
				end
				S_ENV_LO: begin
					plo_q   <= env_mul_c;
					state_q <= S_TRIM;
				end
				S_TRIM: begin
					t_q     <= tsum_c[56:24];
					env_q   <= (ne_c <= ENV_THRESHOLD) ? '0 : ne_c;
					state_q <= S_LEVEL;
				end
				S_LEVEL: begin
					lvl_q   <= lvl_c;
					state_q <= S_SHAPE;
				end
				S_SHAPE: begin
					if (hold_rem_q != '0) begin
						hold_rem_q <= hold_rem_q - 1'b1;
						res_q      <= held_q;
						state_q    <= S_EMIT;
					end else begin
						hold_rem_q <= hc_c - 1'b1;
						if (bits_q >= 5'd16) begin
							held_q  <= pass_c;
							res_q   <= pass_c;
							state_q <= S_EMIT;
						end else begin
							u_q     <= u_c;
							state_q <= S_QUANT;
						end
					end
				end
				S_QUANT: begin
					qprod_q <= u_q * lmax_c;
					state_q <= S_QROUND;
				end
				S_QROUND: begin
					rem_q     <= qsum_c[47:32];
					dvd_q     <= {2'b00, lmax_c};
					quot_q    <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q     <= rem_next_c;
					dvd_q     <= {dvd_q[15:0], 1'b0};
					quot_q    <= quot_next_c;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'(DIV_STEPS - 1)) begin
						held_q  <= crushed_c;
						res_q   <= crushed_c;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_env_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		env_q == '0 || env_q > ENV_THRESHOLD)
		else $error("envelope left inside the dead band");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result loaded outside the emit step");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && div_cnt_q == 5'(DIV_STEPS - 1) |=> state_q == S_EMIT)
		else $error("divide did not finish into emit");
`endif

endmodule

// ----- src/drum_voice_finish_stage_top.sv -----
// Top level of the drum voice finish stage.
// Channels: s_axis carries one event per transfer; tuser is the operation
// (0 sample tick, 1 note trigger, 2 gate level, 3 panic). Each sample tick
// gives exactly one m_axis transfer; other operations give none. The cfg
// channel writes registers 0..4 (mix, level, decay, bits, hold) and is always
// ready; write it only while no event is in flight.
// Inputs land in a two-entry queue; the back end pulls one event at a time.
// Steps per event in the back end, set by its single sequencer:
//   trigger, gate, panic: idle only; tick in a silent chunk: idle, emit;
//   rendered tick repeating the held value, or with 16 bits: idle, blend,
//   envelope high and low halves, trim, level, shape, emit; rendered tick
//   taking a new crushed value below 16 bits: quant, round and the 17-step
//   bit-serial divide come between shape and emit.
// An event queued behind another first waits until that one is finished.
// A stalled m_axis holds the result register; the back end
// then waits at its emit step and the queue fills, dropping s_axis_tready.
// Reset (arst_n low) restores register defaults, clears the envelope,
// chunk counter and queue; no clearing pass is needed.
module drum_voice_finish_stage_top
	import dvf_pkg::*;
#(
	parameter int CHUNK_LENGTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [15:0] dry_sample, [31:16] wet_sample, [38:32] velocity, [39] gate_level
	input  logic [39:0]            s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [15:0] out_sample
	output logic [15:0]            m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	dvf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop)
	);

	dvf_back #(
		.CHUNK_LENGTH (CHUNK_LENGTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ----- bench/testbench.sv -----
// Self-checking stream testbench for the drum voice finish stage, with its scoreboard class.
import dvf_pkg::*;

class voice_scoreboard;
	localparam int CHUNK_LEN = 24;

	logic [15:0] mix_amount;
	logic [15:0] output_level;
	logic [23:0] decay_factor;
	logic [4:0]  resolution_bits;
	logic [4:0]  hold_count;

	logic [23:0] envelope;
	logic [15:0] held_value;
	logic [4:0]  hold_left;
	logic        trig_pending;
	logic        gate_high;
	logic        chunk_live;
	logic [6:0]  last_vel;
	int unsigned chunk_pos;

	logic [15:0] expected_samples[$];
	int unsigned mismatches;

	function new();
		mix_amount      = MIX_RESET;
		output_level    = LEVEL_RESET;
		decay_factor    = DECAY_RESET;
		resolution_bits = BITS_RESET;
		hold_count      = HOLD_RESET;
		envelope        = '0;
		held_value      = '0;
		hold_left       = '0;
		trig_pending    = 1'b0;
		gate_high       = 1'b0;
		chunk_live      = 1'b0;
		last_vel        = VELOCITY_RESET;
		chunk_pos       = 0;
		mismatches      = 0;
	endfunction

	// round half up, then divide by 2^n
	static function longint rounded_shift(longint x, int n);
		return (x + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function logic [15:0] crush_sample(longint v31);
		longint r;
		longint s;
		longint lv;
		longint q;
		int b;
		b = int'(resolution_bits);
		if (b >= 16) begin
			r = rounded_shift(v31, 16);
		end else begin
			if (b < 2) b = 2;
			lv = (longint'(1) <<< b) - 1;
			s = v31 + (longint'(1) <<< 31);
			if (s < 0) s = 0;
			if (s > 64'sd4294967295) s = 64'sd4294967295;
			q = (s * lv + (longint'(1) <<< 31)) >>> 32;
			r = (131072 * q + lv) / (2 * lv) - 32768;
		end
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function void fire_accent(logic [6:0] vel);
		longint acc;
		acc = (((127 + 4 * longint'(vel)) <<< 24) + 317) / 635;
		if (acc > 64'sd16777215) acc = 64'sd16777215;
		last_vel = vel;
		if (acc[23:0] > envelope) envelope = acc[23:0];
		trig_pending = 1'b1;
		hold_left = '0;
	endfunction

	function void write_register(logic [2:0] idx, logic [23:0] val);
		case (idx)
		CFG_MIX_AMOUNT:      mix_amount = val[15:0];
		CFG_OUTPUT_LEVEL:    output_level = val[15:0];
		CFG_DECAY_FACTOR:    decay_factor = val;
		CFG_RESOLUTION_BITS: resolution_bits = val[4:0];
		CFG_HOLD_COUNT:      hold_count = val[4:0];
		default: ;
		endcase
	endfunction

	function void note_event(op_t op, logic signed [15:0] dry, logic signed [15:0] wet,
			logic [6:0] vel, logic gate);
		longint d;
		longint w;
		longint blend;
		longint scaled;
		longint e31;
		longint ne;
		case (op)
		OP_TRIGGER: fire_accent(vel);
		OP_GATE: begin
			if (gate && !gate_high) fire_accent(last_vel);
			gate_high = gate;
		end
		OP_PANIC: begin
			trig_pending = 1'b0;
			gate_high = 1'b0;
			envelope = '0;
			held_value = '0;
			hold_left = '0;
		end
		OP_TICK: begin
			// render decision is taken once per chunk, consuming any pending trigger
			if (chunk_pos == 0) begin
				chunk_live = trig_pending || (envelope > ENV_THRESHOLD);
				trig_pending = 1'b0;
			end
			if (chunk_live) begin
				d = longint'(dry);
				w = longint'(wet);
				blend = d * 65536 + (w - d) * longint'(mix_amount);
				scaled = rounded_shift(blend * longint'(envelope), 24);
				e31 = rounded_shift(scaled * longint'(output_level), 16);
				ne = (longint'(envelope) * longint'(decay_factor) + (longint'(1) <<< 23)) >>> 24;
				envelope = (ne <= longint'(ENV_THRESHOLD)) ? 24'd0 : ne[23:0];
				if (hold_left == 0) begin
					held_value = crush_sample(e31);
					hold_left = (hold_count == 0) ? 5'd0 : hold_count - 5'd1;
				end else begin
					hold_left = hold_left - 5'd1;
				end
				expected_samples.push_back(held_value);
			end else begin
				expected_samples.push_back(16'd0);
			end
			chunk_pos = (chunk_pos + 1 >= CHUNK_LEN) ? 0 : chunk_pos + 1;
		end
		default: ;
		endcase
	endfunction

	function void check_sample(logic [15:0] got);
		logic [15:0] want;
		if (expected_samples.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("out_sample %0d arrived with nothing pending", $signed(got));
		end else begin
			want = expected_samples.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("out_sample mismatch: expected %0d, got %0d",
						$signed(want), $signed(got));
			end
		end
	endfunction

	function int unsigned backlog();
		return expected_samples.size();
	endfunction
endclass

module testbench;
	localparam int CHUNK_LEN     = 24;
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_COUNT   = 10;
	localparam int PHASE_EVENTS  = 160;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [39:0]            s_axis_tdata = '0;
	logic [1:0]             s_axis_tuser = OP_TICK;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [15:0]            m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_MIX_AMOUNT;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	voice_scoreboard board = new;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	drum_voice_finish_stage_top #(
		.CHUNK_LENGTH(CHUNK_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 15))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'h0000;
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_event(op_t op, logic [15:0] dry, logic [15:0] wet,
			logic [6:0] vel, logic gate);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {gate, vel, wet, dry};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		board.note_event(op, dry, wet, vel, gate);
	endtask

	task automatic send_random_event();
		int pick;
		op_t op;
		pick = $urandom_range(0, 99);
		if (pick < 82) op = OP_TICK;
		else if (pick < 88) op = OP_TRIGGER;
		else if (pick < 97) op = OP_GATE;
		else op = OP_PANIC;
		send_event(op, rand_sample(), rand_sample(), 7'($urandom), 1'($urandom));
	endtask

	// sender goes quiet until every sample is back, then lets trailing events settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (board.backlog() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_register(idx, val);
	endtask

	task automatic configure_phase(int p);
		logic [23:0] mix;
		logic [23:0] level;
		logic [23:0] decay;
		logic [23:0] bits;
		logic [23:0] hold;
		mix   = 24'($urandom_range(0, 65535));
		level = 24'($urandom_range(20000, 65535));
		decay = 24'($urandom_range(15000000, 16777215));
		bits  = 24'($urandom_range(2, 16));
		hold  = 24'($urandom_range(1, 24));
		case (p)
		0: begin
			mix = 24'd0; level = 24'd65535; decay = 24'hFFFFFF; bits = 24'd2; hold = 24'd1;
		end
		1: begin
			mix = 24'd65535; level = 24'd65535; decay = 24'd0; bits = 24'd16; hold = 24'd24;
		end
		2: begin level = 24'd0; bits = 24'd15; end
		// depth and hold below their minimum
		3: begin bits = 24'd1; hold = 24'd0; end
		4: begin bits = 24'd0; hold = 24'd31; decay = 24'd16000000; end
		5: begin bits = 24'd31; decay = 24'd12000000; end
		default: ;
		endcase
		write_register(CFG_MIX_AMOUNT, mix);
		write_register(CFG_OUTPUT_LEVEL, level);
		write_register(CFG_DECAY_FACTOR, decay);
		write_register(CFG_RESOLUTION_BITS, bits);
		write_register(CFG_HOLD_COUNT, hold);
		// spare indexes must leave every register alone
		if (p < 3 || $urandom_range(0, 1) == 1)
			write_register(CFG_HOLD_COUNT + 3'($urandom_range(1, 3)), 24'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_event(OP_TRIGGER, 16'h0000, 16'h0000, 7'd127, 1'b0);
		send_event(OP_TICK, 16'h7FFF, 16'h8000, 7'd0, 1'b0);
		send_event(OP_TICK, 16'h8000, 16'h7FFF, 7'd127, 1'b1);
		send_event(OP_TICK, 16'h7FFF, 16'h7FFF, 7'd0, 1'b0);
		send_event(OP_TICK, 16'h8000, 16'h8000, 7'd0, 1'b0);
		// rising gate retriggers with the stored velocity, a held gate does not
		send_event(OP_GATE, 16'h0000, 16'h0000, 7'd0, 1'b1);
		send_event(OP_GATE, 16'hFFFF, 16'hFFFF, 7'd127, 1'b1);
		send_event(OP_TICK, 16'hFFFF, 16'h0001, 7'd0, 1'b0);
		// chunk keeps rendering after a panic, but from a cleared envelope
		send_event(OP_PANIC, 16'h0000, 16'h0000, 7'd0, 1'b0);
		send_event(OP_TICK, 16'h1234, 16'h4321, 7'd0, 1'b0);
		send_event(OP_GATE, 16'h0000, 16'h0000, 7'd0, 1'b0);
		send_event(OP_GATE, 16'h0000, 16'h0000, 7'd0, 1'b1);
		send_event(OP_TICK, 16'h4000, 16'hC000, 7'd0, 1'b0);
		send_event(OP_TRIGGER, 16'h0000, 16'h0000, 7'd0, 1'b0);
		send_event(OP_TICK, 16'h0000, 16'h0000, 7'd0, 1'b0);
		send_event(OP_TICK, 16'h7FFF, 16'h7FFF, 7'd0, 1'b0);
		repeat (8) send_event(OP_TICK, rand_sample(), rand_sample(), 7'd0, 1'b0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_idle();
			configure_phase(p);
			tx_steady = ($urandom_range(0, 3) == 0);
			repeat (PHASE_EVENTS) send_random_event();
		end
		wait_idle();
		if (board.mismatches == 0 && board.backlog() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// result side: random stalls, with spells of steady acceptance
	initial begin
		int stall;
		int span;
		stall = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) board.check_sample(m_axis_tdata);
			if (span == 0) begin
				rx_steady = ($urandom_range(0, 3) == 0);
				span = $urandom_range(100, 400);
			end else begin
				span--;
			end
			if (stall > 0)
				stall--;
			else if (!rx_steady && $urandom_range(0, 99) < 30)
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
					: $urandom_range(1, 3);
			m_axis_tready <= (stall == 0);
		end
	end

	initial begin
		#(LIMIT_CYCLES * 8);
		$display("FAILED: results differ");
		$finish;
	end
endmodule
